@@ hdl/ptagc_pkg.sv @@
package ptagc_pkg;

    // Default values of the top-level parameters.
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int TARGET_W   = 15;
    localparam int WEIGHT_W   = 16;
    localparam int PEAK_W     = 24;
    localparam int PEAK_FRAC  = 23;
    localparam int GAIN_OUT_W = 23;
    localparam int GAIN_INT_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;

    // Register reset values.
    localparam logic [TARGET_W-1:0] TARGET_RST  = 15'd16384;
    localparam logic [WEIGHT_W-1:0] ATTACK_RST  = 16'd655;
    localparam logic [WEIGHT_W-1:0] RELEASE_RST = 16'd66;

    // Fixed smoothing weight of the gain, 0.01 in Q0.16.
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT = 16'd655;

endpackage

@@ hdl/ptagc_if.sv @@
// Sample channel: one input word per handshake.
interface ptagc_in_if #(
    parameter int SAMPLE_BITS = ptagc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_block_in;

    modport source (output valid, output sample_in, output end_of_block_in, input ready);
    modport sink   (input valid, input sample_in, input end_of_block_in, output ready);
endinterface

// Result channel: one output word per handshake.
interface ptagc_out_if #(
    parameter int SAMPLE_BITS = ptagc_pkg::SAMPLE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [SAMPLE_BITS-1:0]      sample_out;
    logic [ptagc_pkg::GAIN_OUT_W-1:0]   gain_now;
    logic                               end_of_block_out;

    modport source (output valid, output sample_out, output gain_now,
                    output end_of_block_out, input ready);
    modport sink   (input valid, input sample_out, input gain_now,
                    input end_of_block_out, output ready);
endinterface

@@ hdl/peak_tracking_agc_unit.sv @@
// Channel   Direction  Word
// samples   in         sample_in, end_of_block_in
// results   out        sample_out, gain_now, end_of_block_out
// cfg_*     in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// Each sample passes through the bit-serial shift-add multiplier (used three times
// per sample) and the restoring divider for the target gain, which retires one
// quotient bit a cycle; a new sample is taken only once the last one is through.
// rst_n clears the peak to 0, the gain to 1.0 and the registers to their defaults.
// A finished word waits in the output register; the next sample is taken meanwhile,
// and the block holds in its last step only if that register is still full.
module peak_tracking_agc_unit #(
    parameter int SAMPLE_BITS    = ptagc_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = ptagc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ptagc_in_if.sink                            samples,
    ptagc_out_if.source                         results,
    input  logic                                cfg_wr_en,
    input  logic [ptagc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptagc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int GFB   = GAIN_FRAC_BITS;
    localparam int PW_PK = ptagc_pkg::PEAK_W;
    localparam int GW    = GFB + ptagc_pkg::GAIN_INT_W;
    localparam int AW    = (PW_PK > GW) ? PW_PK : GW;
    localparam int BW    = (ptagc_pkg::WEIGHT_W > SB) ? ptagc_pkg::WEIGHT_W : SB;
    localparam int PW    = AW + BW;
    localparam int DW    = ptagc_pkg::TARGET_W + 8 + GFB;
    localparam int DVW   = PW_PK + 1;
    localparam int CNT_MAX = (BW > DW) ? BW : DW;
    localparam int CNT_W = $clog2(CNT_MAX);
    localparam int LSH   = ptagc_pkg::PEAK_FRAC - (SB - 1);

    localparam logic [DW-1:0] GAIN_MIN = DW'(((1 << GFB) + 5) / 10);
    localparam logic [DW-1:0] GAIN_MAX = DW'(100) << GFB;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GFB;
    localparam logic [PW-1:0] MOVE_HALF = PW'(1) << (ptagc_pkg::WEIGHT_W - 1);
    localparam logic [PW-1:0] OUT_HALF  = PW'(1) << (GFB - 1);
    localparam logic [PW-1:0] NEG_LIM   = PW'(1) << (SB - 1);
    localparam logic [PW-1:0] POS_LIM   = NEG_LIM - PW'(1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(BW - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_PEAK_MUL = 9'b000000010,
        S_PEAK_UPD = 9'b000000100,
        S_DIV      = 9'b000001000,
        S_GAIN_LD  = 9'b000010000,
        S_GAIN_MUL = 9'b000100000,
        S_GAIN_UPD = 9'b001000000,
        S_OUT_MUL  = 9'b010000000,
        S_OUT_FIN  = 9'b100000000
    } state_t;

    // Control and state registers.
    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [PW_PK-1:0]                    peak_reg, peak_next;
    logic [GW-1:0]                       gain_reg, gain_next;
    logic [ptagc_pkg::TARGET_W-1:0]      target_reg, target_next;
    logic [ptagc_pkg::WEIGHT_W-1:0]      attack_reg, attack_next;
    logic [ptagc_pkg::WEIGHT_W-1:0]      release_reg, release_next;

    // Datapath registers.
    logic [SB-1:0]                       mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic                                eob_reg, eob_next;
    logic                                up_reg, up_next;
    logic [AW-1:0]                       mul_a_reg, mul_a_next;
    logic [BW-1:0]                       mul_b_reg, mul_b_next;
    logic [PW-1:0]                       acc_reg, acc_next;
    logic [DW-1:0]                       dvd_reg, dvd_next;
    logic [DVW-1:0]                      rem_reg, rem_next;
    logic [DVW-1:0]                      den_reg, den_next;
    logic [SB-1:0]                       out_sample_reg, out_sample_next;
    logic [ptagc_pkg::GAIN_OUT_W-1:0]    out_gain_reg, out_gain_next;
    logic                                out_eob_reg, out_eob_next;

    // Combinational helpers.
    logic [SB-1:0]     raw;
    logic              in_neg;
    logic [SB-1:0]     in_mag;
    logic [PW_PK-1:0]  level;
    logic              accept;
    logic [AW:0]       mul_sum;
    logic [PW-1:0]     move_d;
    logic [PW_PK-1:0]  peak_new;
    logic [DVW-1:0]    rem_sh;
    logic              rem_ge;
    logic [GW-1:0]     tgain;
    logic [GW-1:0]     gain_new;
    logic [PW-1:0]     out_r;
    logic [SB-1:0]     res_mag;

    // Sample magnitude and its Q1.23 level.
    assign raw    = samples.sample_in;
    assign in_neg = raw[SB-1];
    assign in_mag = in_neg ? (~raw) + SB'(1) : raw;

    generate
        if (LSH >= 0) begin : g_level_up
            assign level = PW_PK'(in_mag) << LSH;
        end else begin : g_level_down
            assign level = PW_PK'(in_mag >> (-LSH));
        end
    endgenerate

    assign accept = samples.valid && samples.ready;

    // One shift-add step: add the multiplicand into the top of the accumulator.
    assign mul_sum = {1'b0, acc_reg[PW-1:BW]} + (mul_b_reg[0] ? {1'b0, mul_a_reg} : '0);

    // Rounded step of a weighted move, taken from the finished product.
    assign move_d   = (acc_reg + MOVE_HALF) >> ptagc_pkg::WEIGHT_W;
    assign peak_new = up_reg ? peak_reg + move_d[PW_PK-1:0] : peak_reg - move_d[PW_PK-1:0];
    assign gain_new = up_reg ? gain_reg + move_d[GW-1:0] : gain_reg - move_d[GW-1:0];

    // One restoring division step.
    assign rem_sh = {rem_reg[DVW-2:0], dvd_reg[DW-1]};
    assign rem_ge = rem_sh >= den_reg;

    // Clamp of the quotient to the gain limits.
    always_comb
    begin
        if (dvd_reg < GAIN_MIN)
            tgain = GAIN_MIN[GW-1:0];
        else if (dvd_reg > GAIN_MAX)
            tgain = GAIN_MAX[GW-1:0];
        else
            tgain = dvd_reg[GW-1:0];
    end

    // Output rounding and saturation.
    assign out_r = (acc_reg + OUT_HALF) >> GFB;

    always_comb
    begin
        if (neg_reg)
            res_mag = (out_r > NEG_LIM) ? NEG_LIM[SB-1:0] : out_r[SB-1:0];
        else
            res_mag = (out_r > POS_LIM) ? POS_LIM[SB-1:0] : out_r[SB-1:0];
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        peak_next       = peak_reg;
        gain_next       = gain_reg;
        target_next     = target_reg;
        attack_next     = attack_reg;
        release_next    = release_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        eob_next        = eob_reg;
        up_next         = up_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        acc_next        = acc_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        out_eob_next    = out_eob_reg;

        // The taken result word leaves the output register.
        if (results.ready)
            out_valid_next = 1'b0;

        // Configuration writes; unknown indexes are dropped.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ptagc_pkg::REG_TARGET:  target_next  = cfg_data[ptagc_pkg::TARGET_W-1:0];
                ptagc_pkg::REG_ATTACK:  attack_next  = cfg_data[ptagc_pkg::WEIGHT_W-1:0];
                ptagc_pkg::REG_RELEASE: release_next = cfg_data[ptagc_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mag_next   = in_mag;
                    neg_next   = in_neg;
                    eob_next   = samples.end_of_block_in;
                    up_next    = level > peak_reg;
                    mul_a_next = (level > peak_reg) ? AW'(level - peak_reg)
                                                    : AW'(peak_reg - level);
                    mul_b_next = (level > peak_reg) ? BW'(attack_reg) : BW'(release_reg);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_PEAK_MUL;
                end
            end

            S_PEAK_MUL, S_GAIN_MUL, S_OUT_MUL:
            begin
                acc_next   = {mul_sum, acc_reg[BW-1:1]};
                mul_b_next = mul_b_reg >> 1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next = '0;
                    case (state_reg)
                        S_PEAK_MUL: state_next = S_PEAK_UPD;
                        S_GAIN_MUL: state_next = S_GAIN_UPD;
                        default:    state_next = S_OUT_FIN;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_PEAK_UPD:
            begin
                peak_next  = peak_new;
                dvd_next   = DW'(target_reg) << (8 + GFB);
                rem_next   = '0;
                den_next   = DVW'(peak_new) + DVW'(1);
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next = rem_ge ? rem_sh - den_reg : rem_sh;
                dvd_next = {dvd_reg[DW-2:0], rem_ge};
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_GAIN_LD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_GAIN_LD:
            begin
                up_next    = tgain >= gain_reg;
                mul_a_next = (tgain >= gain_reg) ? AW'(tgain - gain_reg)
                                                 : AW'(gain_reg - tgain);
                mul_b_next = BW'(ptagc_pkg::SMOOTH_WEIGHT);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_GAIN_MUL;
            end

            S_GAIN_UPD:
            begin
                gain_next  = gain_new;
                mul_a_next = AW'(gain_new);
                mul_b_next = BW'(mag_reg);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_OUT_MUL;
            end

            S_OUT_FIN:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = neg_reg ? (~res_mag) + SB'(1) : res_mag;
                    out_gain_next   = ptagc_pkg::GAIN_OUT_W'(gain_reg);
                    out_eob_next    = eob_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            gain_reg      <= GAIN_ONE;
            target_reg    <= ptagc_pkg::TARGET_RST;
            attack_reg    <= ptagc_pkg::ATTACK_RST;
            release_reg   <= ptagc_pkg::RELEASE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            peak_reg      <= peak_next;
            gain_reg      <= gain_next;
            target_reg    <= target_next;
            attack_reg    <= attack_next;
            release_reg   <= release_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        eob_reg        <= eob_next;
        up_reg         <= up_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        acc_reg        <= acc_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
        out_eob_reg    <= out_eob_next;
    end

    // Port drive.
    assign samples.ready            = (state_reg == S_IDLE);
    assign results.valid            = out_valid_reg;
    assign results.sample_out       = out_sample_reg;
    assign results.gain_now         = out_gain_reg;
    assign results.end_of_block_out = out_eob_reg;

`ifndef SYNTH
    // An accepted sample starts the peak multiply.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PEAK_MUL)
        else $error("accepted sample did not start the peak multiply");

    // The divisor is never zero while dividing.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("divider runs with a zero divisor");

    // The smoothed gain stays inside the clamp limits after each update.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GAIN_UPD |=> (DW'(gain_reg) >= GAIN_MIN) && (DW'(gain_reg) <= GAIN_MAX))
        else $error("smoothed gain left the clamp range");

    // A new result word appears only from the final step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT_FIN))
        else $error("result word loaded outside the final step");

    // The peak never rises above full scale.
    a_peak_top: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PEAK_UPD |=> peak_reg <= (PW_PK'(1) << ptagc_pkg::PEAK_FRAC))
        else $error("peak tracker exceeded full scale");
`endif

endmodule
